[rtl/barycentric_depth_interp_assert.svh]
// Assertion macros for the depth interpolator.
`ifndef BARYCENTRIC_DEPTH_INTERP_ASSERT_SVH
`define BARYCENTRIC_DEPTH_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
`define BDI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bdi assertion failed");
`define BDI_NEVER(lbl, expr) \
  `BDI_ASSERT(lbl, !(expr))
`else
`define BDI_ASSERT(lbl, prop)
`define BDI_NEVER(lbl, expr)
`endif
`endif

[rtl/bdi_pkg.sv]
package bdi_pkg;

  // Control that travels with each item along the pipeline
  typedef struct packed {
    logic valid;
    logic deg;
    logic sat;
  } ctl_t;

endpackage

[rtl/bdi_front.sv]
module bdi_front #(
  parameter int C = 16,
  parameter int D = 24,
  parameter int AW = 2 * C + 3,
  parameter int NW = AW + D + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic signed [C-1:0] px,
  input  logic signed [C-1:0] py,
  input  logic signed [C-1:0] ax,
  input  logic signed [C-1:0] ay,
  input  logic [D-1:0]        az,
  input  logic signed [C-1:0] bx,
  input  logic signed [C-1:0] by_coord,
  input  logic [D-1:0]        bz,
  input  logic signed [C-1:0] cx,
  input  logic signed [C-1:0] cy,
  input  logic [D-1:0]        cz,
  output bdi_pkg::ctl_t       dn_ctl,
  output logic [NW-1:0]       dn_rem,
  output logic [AW-1:0]       dn_abc,
  input  logic                dn_ready
);

  localparam int CW = C + 1;
  localparam int PW = 2 * CW;

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  // A stage loads when it is empty or its contents move on
  assign r5 = !v5 || dn_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;

  // Stage 1: coordinate differences
  logic signed [CW-1:0] d [10];
  logic [D-1:0] z1a, z1b, z1c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= up_valid;
    end
    if (r1 && up_valid) begin
      d[0] <= CW'(bx) - CW'(ax);
      d[1] <= CW'(by_coord) - CW'(ay);
      d[2] <= CW'(cx) - CW'(ax);
      d[3] <= CW'(cy) - CW'(ay);
      d[4] <= CW'(ax) - CW'(px);
      d[5] <= CW'(ay) - CW'(py);
      d[6] <= CW'(bx) - CW'(px);
      d[7] <= CW'(by_coord) - CW'(py);
      d[8] <= CW'(cx) - CW'(px);
      d[9] <= CW'(cy) - CW'(py);
      z1a  <= az;
      z1b  <= bz;
      z1c  <= cz;
    end
  end

  // Stage 2: cross product terms, u1*v2 and u2*v1 for each area
  logic signed [PW-1:0] p [8];
  logic [D-1:0] z2a, z2b, z2c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      p[0] <= PW'(d[0]) * PW'(d[3]);
      p[1] <= PW'(d[2]) * PW'(d[1]);
      p[2] <= PW'(d[6]) * PW'(d[9]);
      p[3] <= PW'(d[8]) * PW'(d[7]);
      p[4] <= PW'(d[4]) * PW'(d[9]);
      p[5] <= PW'(d[8]) * PW'(d[5]);
      p[6] <= PW'(d[4]) * PW'(d[7]);
      p[7] <= PW'(d[6]) * PW'(d[5]);
      z2a  <= z1a;
      z2b  <= z1b;
      z2c  <= z1c;
    end
  end

  // Stage 3: absolute doubled areas
  logic signed [AW-1:0] x [4];
  logic [AW-1:0] area [4];
  logic [D-1:0] z3a, z3b, z3c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      x[k] = AW'(p[2*k]) - AW'(p[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3 && v2) begin
      for (int k = 0; k < 4; k++) begin
        area[k] <= x[k][AW-1] ? AW'(-x[k]) : AW'(x[k]);
      end
      z3a <= z2a;
      z3b <= z2b;
      z3c <= z2c;
    end
  end

  // Stage 4: weight each vertex depth by its opposite sub-area
  logic [AW+D-1:0] wa, wb, wc;
  logic [AW-1:0] abc4;
  logic deg4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
    if (r4 && v3) begin
      wa   <= (AW+D)'(area[1]) * (AW+D)'(z3a);
      wb   <= (AW+D)'(area[2]) * (AW+D)'(z3b);
      wc   <= (AW+D)'(area[3]) * (AW+D)'(z3c);
      abc4 <= area[0];
      deg4 <= (area[0] == '0);
    end
  end

  // Stage 5: numerator and overflow check against the shifted divisor
  logic [NW-1:0] num;
  logic deg5, sat5;
  assign num = NW'(wa) + NW'(wb) + NW'(wc);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (r5) begin
      v5 <= v4;
    end
    if (r5 && v4) begin
      dn_rem <= num;
      dn_abc <= abc4;
      deg5   <= deg4;
      sat5   <= (num >= (NW'(abc4) << D));
    end
  end

  assign dn_ctl = '{valid: v5, deg: deg5, sat: sat5};

endmodule

[rtl/bdi_div_cell.sv]
module bdi_div_cell #(
  parameter int AW = 35,
  parameter int NW = 61,
  parameter int D = 24,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  bdi_pkg::ctl_t up_ctl,
  input  logic [NW-1:0] up_rem,
  input  logic [AW-1:0] up_abc,
  input  logic [D-1:0]  up_q,
  output logic          up_ready,
  output bdi_pkg::ctl_t dn_ctl,
  output logic [NW-1:0] dn_rem,
  output logic [AW-1:0] dn_abc,
  output logic [D-1:0]  dn_q,
  input  logic          dn_ready
);

  logic [NW-1:0] dsh;
  logic          ge;

  // Try to take one shifted divisor out of the remainder
  assign dsh = NW'(up_abc) << SHIFT;
  assign ge  = (up_rem >= dsh);
  assign up_ready = !dn_ctl.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctl.valid <= 1'b0;
    end else if (up_ready) begin
      dn_ctl.valid <= up_ctl.valid;
    end
    if (up_ready && up_ctl.valid) begin
      dn_ctl.deg <= up_ctl.deg;
      dn_ctl.sat <= up_ctl.sat;
      dn_rem     <= ge ? up_rem - dsh : up_rem;
      dn_abc     <= up_abc;
      dn_q       <= up_q | (D'(ge) << SHIFT);
    end
  end

endmodule

[rtl/barycentric_depth_interp.sv]
// Barycentric depth interpolator.
// Input channel: sample_valid / sample_stall carry a sample point (px, py)
// and three vertices with depths. Output channel: result_valid /
// result_stall carry depth_out and degenerate. A transfer happens on a
// rising edge with valid high and stall low.
// Throughput: one item per cycle while result_stall stays low.
// From input transfer to result_valid an item passes through five front
// stages (differences, cross terms, areas, depth weighting, numerator sum),
// one divider cell per quotient bit, and the output register. The divider
// is a chain of restoring-division cells, each resolving one quotient bit
// and passing the remainder on.
// Zero triangle area gives degenerate = 1 and depth 0; a quotient above
// the depth range saturates to all ones.
// Reset (rst, synchronous) empties every stage; nothing else is kept.
// When the receiver stalls, the held result stays put and items keep
// moving into empty stages behind it; sample_stall rises only once
// every stage is full.
`include "barycentric_depth_interp_assert.svh"

module barycentric_depth_interp #(
  parameter int COORD_BITS = 16,
  parameter int DEPTH_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic [DEPTH_BITS-1:0]        az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by_coord,
  input  logic [DEPTH_BITS-1:0]        bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic [DEPTH_BITS-1:0]        cz,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [DEPTH_BITS-1:0]        depth_out,
  output logic                         degenerate
);

  localparam int D  = DEPTH_BITS;
  localparam int AW = 2 * COORD_BITS + 3;
  localparam int NW = AW + D + 2;

  bdi_pkg::ctl_t ctl [D+1];
  logic [NW-1:0] rem [D+1];
  logic [AW-1:0] abc [D+1];
  logic [D-1:0]  q   [D+1];
  logic          rdy [D+1];
  logic          front_ready;
  logic          out_ready;

  assign q[0] = '0;

  bdi_front #(.C(COORD_BITS), .D(D), .AW(AW), .NW(NW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sample_valid),
    .up_ready (front_ready),
    .px       (px),
    .py       (py),
    .ax       (ax),
    .ay       (ay),
    .az       (az),
    .bx       (bx),
    .by_coord (by_coord),
    .bz       (bz),
    .cx       (cx),
    .cy       (cy),
    .cz       (cz),
    .dn_ctl   (ctl[0]),
    .dn_rem   (rem[0]),
    .dn_abc   (abc[0]),
    .dn_ready (rdy[0])
  );

  assign sample_stall = !front_ready;

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < D; k++) begin : g_cell
    bdi_div_cell #(.AW(AW), .NW(NW), .D(D), .SHIFT(D - 1 - k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_ctl   (ctl[k]),
      .up_rem   (rem[k]),
      .up_abc   (abc[k]),
      .up_q     (q[k]),
      .up_ready (rdy[k]),
      .dn_ctl   (ctl[k+1]),
      .dn_rem   (rem[k+1]),
      .dn_abc   (abc[k+1]),
      .dn_q     (q[k+1]),
      .dn_ready (rdy[k+1])
    );
  end

  // Output register: apply degenerate and saturation, hold while stalled
  assign out_ready = !result_valid || !result_stall;
  assign rdy[D]    = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= ctl[D].valid;
    end
    if (out_ready && ctl[D].valid) begin
      degenerate <= ctl[D].deg;
      if (ctl[D].deg) begin
        depth_out <= '0;
      end else if (ctl[D].sat) begin
        depth_out <= '1;
      end else begin
        depth_out <= q[D];
      end
    end
  end

  `BDI_ASSERT(a_deg_zero, result_valid && degenerate |-> depth_out == '0)
  `BDI_ASSERT(a_hold_valid, result_valid && result_stall |=> result_valid)
  `BDI_ASSERT(a_stall_full, sample_stall |-> result_valid && result_stall)
  `BDI_NEVER(a_no_orphan, sample_stall && !ctl[0].valid)

endmodule
